FILE: design/crsf_pkg.sv
// crsf_pkg: shared types and constants of the CRSF frame receiver
// used by crsf_crc8_serial, crsf_chan_unpack and crsf_frame_receiver; no dependencies
`default_nettype none

package crsf_pkg;

    // crc-8/dvb-s2 generator polynomial, msb first
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // pulse width mapping
    localparam int PULSE_MID_RAW = 992;
    localparam int PULSE_MID_US  = 1500;
    localparam int PULSE_W       = 12;

    // frame length handling (length byte is 6 bits wide after checking)
    localparam int LEN_W      = 6;
    localparam int MIN_LENGTH = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_ADDR  = 2'd0;
    localparam logic [1:0] CFG_CHAN_TYPE  = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

    // register reset values
    localparam logic [7:0]       RST_SYNC_ADDR  = 8'd200;
    localparam logic [7:0]       RST_CHAN_TYPE  = 8'd22;
    localparam logic [LEN_W-1:0] RST_MAX_LENGTH = 6'd62;

    // control from the frame sequencer to the crc unit
    typedef struct packed {
        logic clr;
        logic start;
    } t_crc_ctl;

    // control from the frame sequencer to the channel unpacker
    typedef struct packed {
        logic push;
        logic step;
    } t_chan_ctl;

endpackage

`default_nettype wire

FILE: design/crsf_crc8_serial.sv
// crsf_crc8_serial: bit-serial crc-8/dvb-s2, one bit per cycle
// depends on crsf_pkg
`default_nettype none

module crsf_crc8_serial
    import crsf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_crc_ctl   i_ctl,
    input  wire logic [7:0] i_byte,
    output logic      [7:0] o_crc,
    output logic            o_busy
);

    localparam logic [2:0] LAST_BIT = 3'd7;

    logic [7:0] r_crc, n_crc;
    logic [2:0] r_bit, n_bit;
    logic       r_busy, n_busy;

    // fold the byte in at start, then shift one bit per cycle
    always_comb begin
        n_crc  = r_crc;
        n_bit  = r_bit;
        n_busy = r_busy;
        if (i_ctl.clr) begin
            n_crc  = 8'd0;
            n_busy = 1'b0;
        end else if (i_ctl.start) begin
            n_crc  = r_crc ^ i_byte;
            n_bit  = 3'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_crc = {r_crc[6:0], 1'b0} ^ (r_crc[7] ? CRC_POLY : 8'd0);
            n_bit = r_bit + 3'd1;
            if (r_bit == LAST_BIT) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= 8'd0;
            r_bit  <= 3'd0;
            r_busy <= 1'b0;
        end else begin
            r_crc  <= n_crc;
            r_bit  <= n_bit;
            r_busy <= n_busy;
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

FILE: design/crsf_chan_unpack.sv
// crsf_chan_unpack: payload shift register, bytes in, one packed channel out per step
// depends on crsf_pkg
`default_nettype none

module crsf_chan_unpack
    import crsf_pkg::*;
#(
    parameter int CHANNEL_COUNT = 16,
    parameter int CHANNEL_BITS  = 11
) (
    input  wire logic                    i_clk,
    input  wire t_chan_ctl               i_ctl,
    input  wire logic [7:0]              i_byte,
    output logic      [CHANNEL_BITS-1:0] o_raw,
    output logic      [PULSE_W-1:0]      o_pulse
);

    localparam int PAYLOAD_BYTES = (CHANNEL_COUNT * CHANNEL_BITS + 7) / 8;
    localparam int SR_W          = PAYLOAD_BYTES * 8;
    // difference to the mid value and its times-five product
    localparam int D_W = 18;
    localparam int M_W = D_W + 3;

    logic [SR_W-1:0] r_sr;

    logic signed [D_W-1:0] w_diff;
    logic signed [M_W-1:0] w_prod;
    logic signed [M_W-1:0] w_quot;

    // bytes enter at the top, so payload byte 0 ends at the bottom;
    // each step drops the channel just read, lsb first
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_sr <= (r_sr >> 8) | (SR_W'(i_byte) << (SR_W - 8));
        end else if (i_ctl.step) begin
            r_sr <= r_sr >> CHANNEL_BITS;
        end
    end

    assign o_raw = r_sr[CHANNEL_BITS-1:0];

    // (raw - mid) * 5 / 8 truncated toward zero, plus the mid pulse width
    assign w_diff = $signed(D_W'(o_raw)) - $signed(D_W'(PULSE_MID_RAW));
    assign w_prod = (M_W'(w_diff) <<< 2) + M_W'(w_diff);
    assign w_quot = w_prod[M_W-1] ? ((w_prod + M_W'(7)) >>> 3) : (w_prod >>> 3);
    assign o_pulse = w_quot[PULSE_W-1:0] + PULSE_W'(PULSE_MID_US);

endmodule

`default_nettype wire

FILE: design/crsf_frame_receiver.sv
// crsf_frame_receiver: byte-serial crsf frame parser with crc check and channel decode.
// body bytes but the closing one start the bit-serial crc unit; input waits while it is
// busy or results are emitted. the closing byte sets the emit state, which loads its status
// request into the output register; a good channel frame then adds CHANNEL_COUNT channel
// requests, one per cycle while the output is taken. input resumes after the last.
// reset: synchronous active low; clears parser state and loads default register values.
`default_nettype none

module crsf_frame_receiver
    import crsf_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64,
    parameter int CHANNEL_COUNT   = 16,
    parameter int CHANNEL_BITS    = 11
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // byte input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    // results
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_frame_end,
    output logic             o_crc_good,
    output logic             o_is_channel,
    output logic      [3:0]  o_channel_number,
    output logic      [10:0] o_raw_value,
    output logic      [11:0] o_pulse_us,
    output logic             o_last
);

    localparam int PAYLOAD_BYTES = (CHANNEL_COUNT * CHANNEL_BITS + 7) / 8;
    localparam int RES_W         = $clog2(CHANNEL_COUNT + 1);
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_FRAME_BYTES - 2);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_BODY
    } t_phase;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // configuration registers
    logic [7:0]       r_sync_addr;
    logic [7:0]       r_chan_type;
    logic [LEN_W-1:0] r_max_len;

    // parser and sequencer state
    t_phase           r_phase, n_phase;
    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_kind, n_kind;
    logic             r_good, n_good;
    logic             r_decode, n_decode;
    logic [RES_W-1:0] r_res, n_res;

    // output register
    logic             r_out_valid, n_out_valid;
    logic             r_out_good, n_out_good;
    logic             r_out_is_ch, n_out_is_ch;
    logic [3:0]       r_out_ch, n_out_ch;
    logic [10:0]      r_out_raw, n_out_raw;
    logic [11:0]      r_out_pulse, n_out_pulse;
    logic             r_out_last, n_out_last;

    t_crc_ctl              w_crc_ctl;
    t_chan_ctl             w_chan_ctl;
    logic [7:0]            w_crc;
    logic                  w_crc_busy;
    logic [CHANNEL_BITS-1:0] w_raw;
    logic [PULSE_W-1:0]    w_pulse;
    logic                  w_accept;
    logic                  w_slot_free;
    logic [LEN_W-1:0]      w_limit;
    logic                  w_len_bad;
    logic                  w_frame_done;
    logic                  w_last_ch;

    crsf_crc8_serial u_crc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_crc_ctl),
        .i_byte (i_rx_byte),
        .o_crc  (w_crc),
        .o_busy (w_crc_busy)
    );

    crsf_chan_unpack #(
        .CHANNEL_COUNT(CHANNEL_COUNT),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_chan (
        .i_clk  (i_clk),
        .i_ctl  (w_chan_ctl),
        .i_byte (i_rx_byte),
        .o_raw  (w_raw),
        .o_pulse(w_pulse)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_addr <= RST_SYNC_ADDR;
            r_chan_type <= RST_CHAN_TYPE;
            r_max_len   <= RST_MAX_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_ADDR:  r_sync_addr <= i_cfg_data;
                CFG_CHAN_TYPE:  r_chan_type <= i_cfg_data;
                CFG_MAX_LENGTH: r_max_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake and frame checks
    assign o_in_ready   = (r_state == ST_IDLE) && !w_crc_busy;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign w_limit      = (r_max_len > LEN_CAP) ? LEN_CAP : r_max_len;
    assign w_len_bad    = (i_rx_byte < 8'(MIN_LENGTH)) || (i_rx_byte > {2'b00, w_limit});
    assign w_frame_done = ({1'b0, r_count} + 7'd1) >= {1'b0, r_len};
    assign w_last_ch    = (r_res == RES_W'(CHANNEL_COUNT));

    // parser, result sequencer and output register next values
    always_comb begin
        n_phase     = r_phase;
        n_state     = r_state;
        n_count     = r_count;
        n_len       = r_len;
        n_kind      = r_kind;
        n_good      = r_good;
        n_decode    = r_decode;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_good  = r_out_good;
        n_out_is_ch = r_out_is_ch;
        n_out_ch    = r_out_ch;
        n_out_raw   = r_out_raw;
        n_out_pulse = r_out_pulse;
        n_out_last  = r_out_last;
        w_crc_ctl   = '0;
        w_chan_ctl  = '0;

        if (w_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_sync_addr) begin
                        n_phase       = PH_LENGTH;
                        n_count       = '0;
                        w_crc_ctl.clr = 1'b1;
                    end
                end
                PH_LENGTH: begin
                    n_count       = '0;
                    w_crc_ctl.clr = 1'b1;
                    if (w_len_bad) begin
                        n_phase = PH_HUNT;
                        n_len   = '0;
                        n_kind  = '0;
                    end else begin
                        n_phase = PH_BODY;
                        n_len   = i_rx_byte[LEN_W-1:0];
                    end
                end
                PH_BODY: begin
                    if (w_frame_done) begin
                        n_good   = (i_rx_byte == w_crc);
                        n_decode = (i_rx_byte == w_crc) && (r_kind == r_chan_type) &&
                                   ({1'b0, r_len} == 7'(PAYLOAD_BYTES + 2));
                        n_state  = ST_EMIT;
                        n_res    = '0;
                        n_phase  = PH_HUNT;
                        n_count  = '0;
                        n_len    = '0;
                        n_kind   = '0;
                        w_crc_ctl.clr = 1'b1;
                    end else begin
                        w_crc_ctl.start = 1'b1;
                        if (r_count == '0) begin
                            n_kind = i_rx_byte;
                        end else if ({1'b0, r_count} <= 7'(PAYLOAD_BYTES)) begin
                            w_chan_ctl.push = 1'b1;
                        end
                        n_count = r_count + LEN_W'(1);
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end

        // one result per free output slot: status first, then channels if decoded
        if (r_state == ST_EMIT && w_slot_free) begin
            n_out_valid = 1'b1;
            n_out_good  = r_good;
            if (r_res == '0) begin
                n_out_is_ch = 1'b0;
                n_out_ch    = 4'd0;
                n_out_raw   = 11'd0;
                n_out_pulse = 12'd0;
                n_out_last  = !r_decode;
                if (!r_decode) begin
                    n_state = ST_IDLE;
                end
            end else begin
                n_out_is_ch     = 1'b1;
                n_out_ch        = 4'(r_res - RES_W'(1));
                n_out_raw       = 11'(w_raw);
                n_out_pulse     = w_pulse;
                n_out_last      = w_last_ch;
                w_chan_ctl.step = 1'b1;
                if (w_last_ch) begin
                    n_state = ST_IDLE;
                end
            end
            n_res = r_res + RES_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_len       <= '0;
            r_kind      <= '0;
            r_good      <= 1'b0;
            r_decode    <= 1'b0;
            r_res       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_state     <= n_state;
            r_count     <= n_count;
            r_len       <= n_len;
            r_kind      <= n_kind;
            r_good      <= n_good;
            r_decode    <= n_decode;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
        r_out_good  <= n_out_good;
        r_out_is_ch <= n_out_is_ch;
        r_out_ch    <= n_out_ch;
        r_out_raw   <= n_out_raw;
        r_out_pulse <= n_out_pulse;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_end      = 1'b1;
    assign o_crc_good       = r_out_good;
    assign o_is_channel     = r_out_is_ch;
    assign o_channel_number = r_out_ch;
    assign o_raw_value      = r_out_raw;
    assign o_pulse_us       = r_out_pulse;
    assign o_last           = r_out_last;

`ifndef NO_ASSERTIONS
    // channel requests only follow a good crc
    a_chan_good : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_channel) |-> o_crc_good)
        else $error("channel request without good crc");

    // a failed crc ends the burst with its status request
    a_bad_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_channel && !o_crc_good) |-> o_last)
        else $error("bad crc status not last");

    // a burst has no gaps once started
    a_no_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> o_out_valid)
        else $error("gap inside result burst");

    // channel numbers count up by one
    a_ch_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_is_channel && !o_last) |=>
        (o_channel_number == 4'($past(o_channel_number) + 4'd1)))
        else $error("channel number out of sequence");
`endif

endmodule

`default_nettype wire

FILE: dv/crsf_frame_receiver_tb.sv
// crsf_frame_receiver_tb: self-checking bench for the crsf frame receiver
// byte stream in, status and channel results out, checked against an in-bench predictor
// depends on crsf_pkg and crsf_frame_receiver
`timescale 1ns / 100ps

module crsf_frame_receiver_tb;
    import crsf_pkg::*;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int CHANNEL_COUNT   = 16;
    localparam int CHANNEL_BITS    = 11;
    localparam int PAYLOAD_BYTES   = (CHANNEL_COUNT * CHANNEL_BITS + 7) / 8;
    localparam int SEGMENTS        = 7;
    localparam int SEGMENT_BYTES   = 8;
    localparam int FORCED_FRAMES   = 2;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_PRINTED     = 60;

    // parser phase of the predictor
    typedef enum logic [1:0] {
        SEEK_ADDR,
        TAKE_LENGTH,
        TAKE_BODY
    } t_parse_phase;

    // how a stimulus row is sent and checked
    typedef enum logic [1:0] {
        ROW_BYTE,       // byte as given, results from the predictor
        ROW_CRC,        // running crc sent as the closing byte, results from the predictor
        ROW_END_GOOD,   // closing byte, one status request with crc good
        ROW_END_BAD     // closing byte, one status request with crc bad
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] value;
    } t_stim_row;

    typedef struct packed {
        logic        frame_end;
        logic        crc_good;
        logic        is_channel;
        logic [3:0]  channel_number;
        logic [10:0] raw_value;
        logic [11:0] pulse_us;
        logic        last;
    } t_rc_result;

    typedef struct packed {
        logic [7:0] sync;
        logic [7:0] chan_type;
        logic [7:0] max_len;
        logic [7:0] idle_pct;
        logic [7:0] stall_pct;
    } t_phase_setting;

    // dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_frame_end;
    logic        o_crc_good;
    logic        o_is_channel;
    logic [3:0]  o_channel_number;
    logic [10:0] o_raw_value;
    logic [11:0] o_pulse_us;
    logic        o_last;

    // predictor state and register copies
    t_parse_phase prs_phase;
    logic [6:0]   body_idx;
    logic [5:0]   frame_len;
    logic [7:0]   crc_run;
    logic [7:0]   frame_type;
    logic [7:0]   payload_bytes [PAYLOAD_BYTES];
    logic [7:0]   cfg_sync;
    logic [7:0]   cfg_chan_type;
    logic [5:0]   cfg_max_len;

    t_rc_result byte_results [$];
    t_rc_result pending_results [$];
    t_rc_result want;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int hold_request    = 0;
    int mismatch_count  = 0;
    int bytes_sent      = 0;
    int status_seen     = 0;
    int good_seen       = 0;
    int channel_seen    = 0;

    // directed rows, run with reset register values
    t_stim_row directed_rows [24] = '{
        '{ROW_BYTE, 8'h00},             // hunting ignores extremes
        '{ROW_BYTE, 8'hFF},
        '{ROW_BYTE, RST_SYNC_ADDR},     // shortest frame, type zero, crc zero
        '{ROW_BYTE, 8'h02},
        '{ROW_BYTE, 8'h00},
        '{ROW_END_GOOD, 8'h00},
        '{ROW_BYTE, RST_SYNC_ADDR},     // type all ones, zero crc is wrong
        '{ROW_BYTE, 8'h02},
        '{ROW_BYTE, 8'hFF},
        '{ROW_END_BAD, 8'h00},
        '{ROW_BYTE, RST_SYNC_ADDR},     // lengths below minimum drop
        '{ROW_BYTE, 8'h01},
        '{ROW_BYTE, RST_SYNC_ADDR},
        '{ROW_BYTE, 8'h00},
        '{ROW_BYTE, RST_SYNC_ADDR},     // lengths above limit drop
        '{ROW_BYTE, 8'h3F},
        '{ROW_BYTE, RST_SYNC_ADDR},
        '{ROW_BYTE, 8'hFF},
        '{ROW_BYTE, RST_SYNC_ADDR},     // address bytes inside a frame are data
        '{ROW_BYTE, 8'h04},
        '{ROW_BYTE, RST_SYNC_ADDR},
        '{ROW_BYTE, RST_SYNC_ADDR},
        '{ROW_BYTE, RST_SYNC_ADDR},
        '{ROW_CRC, 8'h00}
    };

    // register settings and idling per random phase
    t_phase_setting phase_settings [SEGMENTS] = '{
        '{RST_SYNC_ADDR, RST_CHAN_TYPE, 8'd62, 8'd0, 8'd0},
        '{8'h00, 8'hFF, 8'hFF, 8'd73, 8'd0},
        '{8'hFF, 8'h00, 8'd24, 8'd0, 8'd73},
        '{8'h5A, RST_CHAN_TYPE, 8'd2, 8'd21, 8'd21},
        '{RST_SYNC_ADDR, RST_CHAN_TYPE, 8'd0, 8'd0, 8'd0},
        '{8'h33, 8'h7E, 8'd1, 8'd73, 8'd0},
        '{RST_SYNC_ADDR, RST_CHAN_TYPE, 8'd62, 8'd0, 8'd73}
    };

    crsf_frame_receiver #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CHANNEL_COUNT   (CHANNEL_COUNT),
        .CHANNEL_BITS    (CHANNEL_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_frame_end      (o_frame_end),
        .o_crc_good       (o_crc_good),
        .o_is_channel     (o_is_channel),
        .o_channel_number (o_channel_number),
        .o_raw_value      (o_raw_value),
        .o_pulse_us       (o_pulse_us),
        .o_last           (o_last)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // crc-8/dvb-s2, one byte msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int i = 0; i < 8; i++)
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void restart_parser();
        prs_phase  = SEEK_ADDR;
        body_idx   = '0;
        frame_len  = '0;
        crc_run    = '0;
        frame_type = '0;
    endfunction

    // advance the predictor by one byte, results land in byte_results
    function automatic void decode_rx_byte(input logic [7:0] b);
        int          limit;
        int          pos;
        int          us;
        logic        crc_ok;
        logic        send_channels;
        logic [10:0] raw;
        t_rc_result  r;
        byte_results.delete();
        case (prs_phase)
            SEEK_ADDR: begin
                if (b == cfg_sync) begin
                    prs_phase = TAKE_LENGTH;
                    body_idx  = '0;
                    crc_run   = '0;
                end
            end
            TAKE_LENGTH: begin
                limit = (cfg_max_len > MAX_FRAME_BYTES - 2) ? MAX_FRAME_BYTES - 2 : cfg_max_len;
                if (b < MIN_LENGTH || b > limit) begin
                    restart_parser();
                end else begin
                    frame_len = b[5:0];
                    body_idx  = '0;
                    crc_run   = '0;
                    prs_phase = TAKE_BODY;
                end
            end
            default: begin
                if (body_idx + 1 >= frame_len) begin
                    // closing byte: status, then channels on a good channel frame
                    crc_ok = (b == crc_run);
                    send_channels = crc_ok && frame_type == cfg_chan_type &&
                                    frame_len == PAYLOAD_BYTES + 2;
                    r = '0;
                    r.frame_end = 1'b1;
                    r.crc_good  = crc_ok;
                    r.last      = !send_channels;
                    byte_results.push_back(r);
                    if (send_channels) begin
                        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                            raw = '0;
                            for (int k = 0; k < CHANNEL_BITS; k++) begin
                                pos = ch * CHANNEL_BITS + k;
                                raw[k] = payload_bytes[pos / 8][pos % 8];
                            end
                            us = (int'(raw) - PULSE_MID_RAW) * 5 / 8 + PULSE_MID_US;
                            r = '0;
                            r.frame_end      = 1'b1;
                            r.crc_good       = 1'b1;
                            r.is_channel     = 1'b1;
                            r.channel_number = ch[3:0];
                            r.raw_value      = raw;
                            r.pulse_us       = us[11:0];
                            r.last           = (ch == CHANNEL_COUNT - 1);
                            byte_results.push_back(r);
                        end
                    end
                    restart_parser();
                end else begin
                    crc_run = crc8_step(crc_run, b);
                    if (body_idx == 0)
                        frame_type = b;
                    else if (body_idx - 1 < PAYLOAD_BYTES)
                        payload_bytes[body_idx - 1] = b;
                    body_idx = body_idx + 1'b1;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, exp_val);
    endtask

    // offer one byte request, wait for acceptance, then predict
    task automatic send_byte(input logic [7:0] b, input t_row_kind kind);
        t_rc_result status;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        decode_rx_byte(b);
        if (kind == ROW_END_GOOD || kind == ROW_END_BAD) begin
            status = '0;
            status.frame_end = 1'b1;
            status.crc_good  = (kind == ROW_END_GOOD);
            status.last      = 1'b1;
            pending_results.push_back(status);
        end else begin
            foreach (byte_results[i])
                pending_results.push_back(byte_results[i]);
        end
    endtask

    // one random frame: mostly well formed, some drops, bad crcs and line noise
    task automatic send_frame(input bit force_chan);
        int         pick;
        int         len;
        int         lim;
        int         fill;
        logic [7:0] kind_byte;
        logic [7:0] data;
        logic [7:0] crc;
        lim  = (cfg_max_len > MAX_FRAME_BYTES - 2) ? MAX_FRAME_BYTES - 2 : cfg_max_len;
        pick = force_chan ? 0 : $urandom_range(99);
        if (pick >= 92) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)), ROW_BYTE);
            return;
        end
        send_byte(cfg_sync, ROW_BYTE);
        if (pick < 40 && lim >= PAYLOAD_BYTES + 2)
            len = PAYLOAD_BYTES + 2;
        else if (pick >= 40 && pick < 50)
            len = $urandom_range(1) ? $urandom_range(1) : $urandom_range(255, lim + 1);
        else if (pick >= 50 && pick < 60 && lim >= PAYLOAD_BYTES + 3)
            len = $urandom_range(lim, PAYLOAD_BYTES + 3);
        else
            len = (lim >= MIN_LENGTH) ? $urandom_range(lim, MIN_LENGTH) : $urandom_range(5);
        send_byte(8'(len), ROW_BYTE);
        if (len < MIN_LENGTH || len > lim)
            return;
        // channel type on channel and oversized frames, sometimes on others
        if (pick < 40 || (pick >= 50 && pick < 60) || $urandom_range(3) == 0)
            kind_byte = cfg_chan_type;
        else
            kind_byte = 8'($urandom_range(255));
        fill = $urandom_range(9);
        crc  = crc8_step(8'h00, kind_byte);
        send_byte(kind_byte, ROW_BYTE);
        for (int i = 0; i < len - 2; i++) begin
            data = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(255));
            crc  = crc8_step(crc, data);
            send_byte(data, ROW_BYTE);
        end
        if ($urandom_range(99) >= 85)
            crc = crc ^ 8'($urandom_range(255, 1));
        send_byte(crc, ROW_BYTE);
    endtask

    // drop valid, wait for every expected request, let the body pipeline drain
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side ready, with a long hold-off on request
    initial begin : result_ready_driver
        int hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected, channel", o_channel_number, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_frame_end !== want.frame_end)
                    report_mismatch("frame_end", o_frame_end, want.frame_end);
                if (o_crc_good !== want.crc_good)
                    report_mismatch("crc_good", o_crc_good, want.crc_good);
                if (o_is_channel !== want.is_channel)
                    report_mismatch("is_channel", o_is_channel, want.is_channel);
                if (o_channel_number !== want.channel_number)
                    report_mismatch("channel_number", o_channel_number, want.channel_number);
                if (o_raw_value !== want.raw_value)
                    report_mismatch("raw_value", o_raw_value, want.raw_value);
                if (o_pulse_us !== want.pulse_us)
                    report_mismatch("pulse_us", o_pulse_us, want.pulse_us);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
                if (want.is_channel)
                    channel_seen++;
                else begin
                    status_seen++;
                    if (want.crc_good)
                        good_seen++;
                end
            end
        end
    end

    // run limit
    initial begin : run_limit
        #3_000_000;
        $display("crsf_frame_receiver: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]     b;
        int             seg_start;
        t_phase_setting s;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_SYNC_ADDR;
        i_cfg_data  <= 8'h00;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= 8'h00;
        cfg_sync      = RST_SYNC_ADDR;
        cfg_chan_type = RST_CHAN_TYPE;
        cfg_max_len   = RST_MAX_LENGTH;
        foreach (payload_bytes[i])
            payload_bytes[i] = 8'h00;
        restart_parser();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table with reset register values
        sender_idle_pct = 21;
        stall_pct       = 21;
        foreach (directed_rows[i]) begin
            b = (directed_rows[i].kind == ROW_CRC) ? crc_run : directed_rows[i].value;
            send_byte(b, directed_rows[i].kind);
        end
        settle_idle();

        // random phases, each with its own registers and idling
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            s = phase_settings[seg];
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_SYNC_ADDR;
            i_cfg_data  <= s.sync;
            @(posedge i_clk);
            i_cfg_index <= CFG_CHAN_TYPE;
            i_cfg_data  <= s.chan_type;
            @(posedge i_clk);
            i_cfg_index <= CFG_MAX_LENGTH;
            i_cfg_data  <= s.max_len;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            cfg_sync      = s.sync;
            cfg_chan_type = s.chan_type;
            cfg_max_len   = s.max_len[5:0];
            sender_idle_pct = s.idle_pct;
            stall_pct       = s.stall_pct;
            seg_start = bytes_sent;
            // last phase: long hold-off on the result side while channel frames keep coming
            if (seg == SEGMENTS - 1) begin
                hold_request = HOLD_OFF_CYCLES;
                repeat (FORCED_FRAMES) send_frame(1'b1);
            end
            while (bytes_sent - seg_start < SEGMENT_BYTES)
                send_frame(1'b0);
            settle_idle();
        end

        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        $display("covered %0d bytes over %0d register settings, with idling and a long stall",
                 bytes_sent, SEGMENTS + 1);
        $display("checked %0d status (%0d crc good) and %0d channel results",
                 status_seen, good_seen, channel_seen);
        if (mismatch_count == 0)
            $display("crsf_frame_receiver: match");
        else
            $display("crsf_frame_receiver: mismatch");
        $finish;
    end

endmodule
